// ===== design/symbol_hash_table_macros.svh =====
// Assertion macros shared by the symbol table checker.
`ifndef SYMBOL_HASH_TABLE_MACROS_SVH
`define SYMBOL_HASH_TABLE_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define SHT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("symbol table check failed");

// Next-cycle implication, ignored while reset is high.
`define SHT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("symbol table check failed");

// Next-cycle implication that also holds across reset.
`define SHT_ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("symbol table check failed");

`endif

// ===== design/sht_pkg.sv =====
// Types, constants and field layout for the symbol table store.
package sht_pkg;

  // Default sizes.
  localparam int TABLE_SLOTS_DEF = 512;
  localparam int NAME_CHARS_DEF  = 8;

  // Name encoding.
  localparam int         CHAR_W      = 7;
  localparam int         FIELD_CHARS = 8;
  localparam logic [6:0] CHAR_MASK   = 7'o177;

  // Field widths.
  localparam int OPCODE_W = 2;
  localparam int NAME_W   = CHAR_W * FIELD_CHARS;
  localparam int SLOT_W   = 9;
  localparam int CLASS_W  = 4;
  localparam int OFFSET_W = 32;
  localparam int DIM_W    = 16;
  localparam int STATUS_W = 2;

  // Input beat layout, lowest field first.
  localparam int IN_NAME_LSB   = OPCODE_W;
  localparam int IN_SLOT_LSB   = IN_NAME_LSB + NAME_W;
  localparam int IN_CLASS_LSB  = IN_SLOT_LSB + SLOT_W;
  localparam int IN_OFFSET_LSB = IN_CLASS_LSB + CLASS_W;
  localparam int IN_DIM_LSB    = IN_OFFSET_LSB + OFFSET_W;
  localparam int IN_USED_W     = IN_DIM_LSB + DIM_W;
  localparam int S_TDATA_W     = ((IN_USED_W + 7) / 8) * 8;

  // Output beat layout, lowest field first.
  localparam int OUT_SLOT_LSB   = STATUS_W;
  localparam int OUT_CLASS_LSB  = OUT_SLOT_LSB + SLOT_W;
  localparam int OUT_USED_W     = OUT_CLASS_LSB + CLASS_W + OFFSET_W + DIM_W;
  localparam int M_TDATA_W      = ((OUT_USED_W + 7) / 8) * 8;

  // Attribute word: class, offset, dimension from the low bits up.
  localparam int ATTR_W = CLASS_W + OFFSET_W + DIM_W;

  localparam logic [CLASS_W-1:0] KEYWORD_CLASS_RST = 4'd1;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_WRITE  = 2'd1,
    OP_FLUSH  = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_FOUND    = 2'd0,
    STAT_INSERTED = 2'd1,
    STAT_OVERFLOW = 2'd2,
    STAT_DONE     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_WRITE,
    S_FLUSH,
    S_DONE
  } state_t;

endpackage

// ===== design/symbol_hash_table.sv =====
// Symbol table store: open-addressing hash table with linear probing.
//
//  Channel  Signals                           Beat contents (low bits first)
//  -------  --------------------------------  ----------------------------------------
//  s        s_tvalid s_tready s_tdata[119:0]  opcode, name_chars, slot_index, class_in,
//                                             offset_in, dim_in
//  m        m_tvalid m_tready m_tdata[63:0]   status, slot_out, class_out, offset_out,
//                                             dim_out
//  cfg      cfg_wr_en cfg_wr_data[3:0]        keyword_class
//
// One item is processed at a time. A lookup is accepted, reduces the character sum modulo
// the table size in two steps (a reciprocal multiply for the quotient, then the remainder
// with one correcting subtract), then probes one slot per cycle, the tag memory being read
// one slot ahead of the compare. A write is accepted and then writes the attributes of an
// in-range slot with its result; a flush is accepted, sweeps the table with one
// read-modify-write per slot, and ends with a result. After reset a clearing pass empties
// the table; no item is accepted during it. A new item is accepted while a result waits in
// the output register; a finished item holds its last step until that register is free.
module symbol_hash_table
  import sht_pkg::*;
#(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
  parameter int NAME_CHARS  = NAME_CHARS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // opcode, name_chars, slot_index, class_in, offset_in, dim_in, zero pad
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // status, slot_out, class_out, offset_out, dim_out, zero pad
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic                 cfg_wr_en,
  input  logic [CLASS_W-1:0]   cfg_wr_data
);

  localparam int ACTIVE_CHARS = (NAME_CHARS < FIELD_CHARS) ? NAME_CHARS : FIELD_CHARS;
  localparam int KEY_W        = ACTIVE_CHARS * CHAR_W;
  localparam int TAG_W        = KEY_W + 1;
  localparam int SUM_W        = $clog2(ACTIVE_CHARS * 127 + 1);
  localparam int AW           = $clog2(TABLE_SLOTS);
  localparam int SW           = AW + 1;
  localparam int RED_SH       = SUM_W + AW;
  localparam int RECIP        = (1 << RED_SH) / TABLE_SLOTS;
  localparam int PAD_W        = M_TDATA_W - OUT_USED_W;

  // Control state.
  state_t             state;
  state_t             state_next;
  logic [CLASS_W-1:0] keyword_class;
  logic [SW-1:0]      sweep;
  logic [AW-1:0]      cur;
  logic [AW-1:0]      probes;
  logic [SUM_W-1:0]   rem;
  logic [SUM_W-1:0]   quot;
  logic               step;

  // Item payload.
  logic [KEY_W-1:0]    key_reg;
  logic [SLOT_W-1:0]   wr_slot;
  logic [CLASS_W-1:0]  wr_class;
  logic [OFFSET_W-1:0] wr_offset;
  logic [DIM_W-1:0]    wr_dim;

  // Memories and their ports.
  logic [TAG_W-1:0]  tag_mem  [TABLE_SLOTS];
  logic [ATTR_W-1:0] attr_mem [TABLE_SLOTS];
  logic [TAG_W-1:0]  tag_q;
  logic [ATTR_W-1:0] attr_q;
  logic [AW-1:0]     rd_addr;
  logic              tag_we;
  logic [AW-1:0]     tag_waddr;
  logic [TAG_W-1:0]  tag_wdata;
  logic              attr_we;
  logic [AW-1:0]     attr_waddr;
  logic [ATTR_W-1:0] attr_wdata;

  // Input field views.
  logic [NAME_W-1:0]   in_name;
  logic [KEY_W-1:0]    in_key;
  logic [SUM_W-1:0]    name_sum;
  logic                accept;

  // Step results.
  logic [31:0]         prod;
  logic [31:0]         diff;
  logic [SUM_W-1:0]    quot_est;
  logic [SUM_W-1:0]    rem_step;
  logic [AW-1:0]       cur_inc;
  logic                tag_valid;
  logic                hit_empty;
  logic                hit_match;
  logic                last_probe;
  logic                decided;
  logic                out_free;
  logic                wr_in_range;
  logic [AW-1:0]       flush_addr;
  logic                flush_drop;

  // Result assembly.
  logic                out_load;
  status_t             res_status;
  logic [SLOT_W-1:0]   res_slot;
  logic [CLASS_W-1:0]  res_class;
  logic [OFFSET_W-1:0] res_offset;
  logic [DIM_W-1:0]    res_dim;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign in_name = s_tdata[IN_NAME_LSB +: NAME_W];
  assign in_key  = in_name[KEY_W-1:0];

  // Character sum of the active part of the name.
  always_comb begin
    name_sum = '0;
    for (int k = 0; k < ACTIVE_CHARS; k++) begin
      name_sum = name_sum + SUM_W'(in_name[k*CHAR_W +: CHAR_W] & CHAR_MASK);
    end
  end

  // Reduction modulo the table size: the quotient estimate comes from a reciprocal
  // multiply and is low by at most one, so one compare and subtract finishes it.
  always_comb begin
    prod     = 32'(rem) * 32'(RECIP);
    quot_est = SUM_W'(prod >> RED_SH);
    diff     = 32'(rem) - 32'(quot) * 32'(TABLE_SLOTS);
    rem_step = SUM_W'(diff);
    if (diff >= 32'(TABLE_SLOTS)) begin
      rem_step = SUM_W'(diff - 32'(TABLE_SLOTS));
    end
  end

  // Probe compare on the slot read in the previous cycle.
  assign cur_inc    = (cur == AW'(TABLE_SLOTS - 1)) ? '0 : cur + AW'(1);
  assign tag_valid  = tag_q[TAG_W-1];
  assign hit_empty  = !tag_valid;
  assign hit_match  = (tag_q[KEY_W-1:0] == key_reg);
  assign last_probe = (probes == AW'(TABLE_SLOTS - 1));
  assign decided    = hit_empty || hit_match || last_probe;

  assign wr_in_range = (32'(wr_slot) < 32'(TABLE_SLOTS));

  // Flush works on the slot read in the previous cycle.
  assign flush_addr = AW'(sweep - SW'(1));
  assign flush_drop = (sweep != '0) && tag_valid && (attr_q[CLASS_W-1:0] != keyword_class);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (sweep == SW'(TABLE_SLOTS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (s_tdata[OPCODE_W-1:0])
            OP_LOOKUP: state_next = S_HASH;
            OP_WRITE:  state_next = S_WRITE;
            OP_FLUSH:  state_next = S_FLUSH;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_HASH: begin
        if (!step) begin
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        if (decided && out_free) begin
          state_next = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (sweep == SW'(TABLE_SLOTS)) begin
          state_next = S_DONE;
        end
      end
      S_WRITE, S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // Memory controls and result selection.
  always_comb begin
    rd_addr    = cur_inc;
    tag_we     = 1'b0;
    tag_waddr  = cur;
    tag_wdata  = '0;
    attr_we    = 1'b0;
    attr_waddr = cur;
    attr_wdata = '0;
    out_load   = 1'b0;
    res_status = STAT_DONE;
    res_slot   = '0;
    res_class  = '0;
    res_offset = '0;
    res_dim    = '0;
    unique case (state)
      S_CLEAR: begin
        tag_we     = 1'b1;
        tag_waddr  = AW'(sweep);
        attr_we    = 1'b1;
        attr_waddr = AW'(sweep);
      end
      S_HASH: begin
        rd_addr = AW'(rem_step);
      end
      S_PROBE: begin
        if (decided) begin
          rd_addr = cur;
        end
        if (decided && out_free) begin
          out_load = 1'b1;
          priority if (hit_empty) begin
            tag_we     = 1'b1;
            tag_wdata  = {1'b1, key_reg};
            attr_we    = 1'b1;
            res_status = STAT_INSERTED;
            res_slot   = SLOT_W'(cur);
          end else if (hit_match) begin
            res_status = STAT_FOUND;
            res_slot   = SLOT_W'(cur);
            res_class  = attr_q[CLASS_W-1:0];
            res_offset = attr_q[CLASS_W +: OFFSET_W];
            res_dim    = attr_q[CLASS_W+OFFSET_W +: DIM_W];
          end else begin
            res_status = STAT_OVERFLOW;
          end
        end
      end
      S_WRITE: begin
        if (out_free) begin
          out_load = 1'b1;
          if (wr_in_range) begin
            attr_we    = 1'b1;
            attr_waddr = AW'(wr_slot);
            attr_wdata = {wr_dim, wr_offset, wr_class};
            res_slot   = wr_slot;
            res_class  = wr_class;
            res_offset = wr_offset;
            res_dim    = wr_dim;
          end
        end
      end
      S_FLUSH: begin
        rd_addr   = AW'(sweep);
        tag_we    = flush_drop;
        tag_waddr = flush_addr;
      end
      S_DONE: begin
        out_load = out_free;
      end
      default: begin
        rd_addr = cur_inc;
      end
    endcase
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      sweep         <= '0;
      keyword_class <= KEYWORD_CLASS_RST;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        keyword_class <= cfg_wr_data;
      end
      if (state == S_CLEAR || state == S_FLUSH) begin
        sweep <= sweep + SW'(1);
      end else begin
        sweep <= '0;
      end
    end
  end

  // Item capture, hash reduction and probe position.
  always_ff @(posedge clk) begin
    if (accept) begin
      key_reg   <= in_key;
      wr_slot   <= s_tdata[IN_SLOT_LSB +: SLOT_W];
      wr_class  <= s_tdata[IN_CLASS_LSB +: CLASS_W];
      wr_offset <= s_tdata[IN_OFFSET_LSB +: OFFSET_W];
      wr_dim    <= s_tdata[IN_DIM_LSB +: DIM_W];
      rem       <= name_sum;
      step      <= 1'b1;
    end else if (state == S_HASH && step) begin
      quot <= quot_est;
      step <= 1'b0;
    end
    if (state == S_HASH) begin
      cur    <= AW'(rem_step);
      probes <= '0;
    end else if (state == S_PROBE && !decided) begin
      cur    <= cur_inc;
      probes <= probes + AW'(1);
    end
  end

  // Tag memory: valid bit over the stored name.
  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[tag_waddr] <= tag_wdata;
    end
    tag_q <= tag_mem[rd_addr];
  end

  // Attribute memory: dimension, offset, class.
  always_ff @(posedge clk) begin
    if (attr_we) begin
      attr_mem[attr_waddr] <= attr_wdata;
    end
    attr_q <= attr_mem[rd_addr];
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output register beat.
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {PAD_W'(0), res_dim, res_offset, res_class, res_slot, res_status};
    end
  end

endmodule

// ===== design/sht_checker.sv =====
// Port-level checks for the symbol table store and their binding.
`include "symbol_hash_table_macros.svh"

module sht_checker
  import sht_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic                 m_tvalid,
  input logic                 m_tready
);

  logic [STATUS_W-1:0]                res_status;
  logic [SLOT_W-1:0]                  res_slot;
  logic [M_TDATA_W-OUT_CLASS_LSB-1:0] res_attr;

  // Result beat fields.
  assign res_status = m_tdata[OUT_SLOT_LSB-1:0];
  assign res_slot   = m_tdata[OUT_CLASS_LSB-1:OUT_SLOT_LSB];
  assign res_attr   = m_tdata[M_TDATA_W-1:OUT_CLASS_LSB];

  // A stalled result beat holds.
  `SHT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  // The table is being cleared right after reset, so no item is taken.
  `SHT_ASSERT_NEXT_ALWAYS(a_clear_after_rst, rst, !s_tready)
  // Only one item is in flight: ready drops after an accepted beat.
  `SHT_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready)
  // A new entry starts with cleared attributes.
  `SHT_ASSERT_IMPL(a_insert_clear, m_tvalid && (res_status == STAT_INSERTED), res_attr == '0)
  // An overflow names no slot.
  `SHT_ASSERT_IMPL(a_ovf_zero, m_tvalid && (res_status == STAT_OVERFLOW), (res_slot == '0) && (res_attr == '0))

endmodule

bind symbol_hash_table sht_checker u_sht_checker (.*);
